>>> sv/svpwm_pkg.sv
// ---------------------------------------------------------------------------
// SVPWM timing package
// Shared widths, fixed-point coefficients and the queue item type.
// ---------------------------------------------------------------------------
package svpwm_pkg;

   localparam int VOLT_W = 16;
   localparam int TIME_W = 16;
   localparam int CMP_W  = 15;
   localparam int SEC_W  = 3;
   localparam int NUM_W  = 32;   // signed dwell numerator
   localparam int DIV_W  = 52;   // divider dividend / quotient width
   localparam int DSR_W  = 35;   // divider divisor width
   localparam int RADIX_BITS = 4;
   localparam int DIV_STEPS  = DIV_W / RADIX_BITS;
   localparam int CNT_W      = 4;
   localparam int T_W    = 35;   // signed dwell time
   localparam int ACC_W  = 40;   // compare arithmetic
   localparam int Q_SHIFT = 14;

   // Q2.14 coefficients
   localparam logic signed [NUM_W-1:0] Q_SQRT3        = 32'sd28377;
   localparam logic signed [NUM_W-1:0] Q_HALF_SQRT3   = 32'sd14189;
   localparam logic signed [NUM_W-1:0] Q_THREE_HALVES = 32'sd24576;

   localparam logic [CMP_W-1:0] CMP_MAX = 15'd32767;

   localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd5000;

   // Sector codes A + 2B + 4C
   localparam logic [SEC_W-1:0] SEC_ZERO = 3'd0;
   localparam logic [SEC_W-1:0] SEC_1 = 3'd1;
   localparam logic [SEC_W-1:0] SEC_2 = 3'd2;
   localparam logic [SEC_W-1:0] SEC_3 = 3'd3;
   localparam logic [SEC_W-1:0] SEC_4 = 3'd4;
   localparam logic [SEC_W-1:0] SEC_5 = 3'd5;
   localparam logic [SEC_W-1:0] SEC_6 = 3'd6;
   localparam logic [SEC_W-1:0] SEC_ALL = 3'd7;

   // Classified request waiting for the back end
   typedef struct packed {
      logic [SEC_W-1:0]        sector;
      logic signed [NUM_W-1:0] num1;
      logic signed [NUM_W-1:0] num2;
      logic [VOLT_W-1:0]       bus;
   } svpwm_item_type;

endpackage

>>> sv/svpwm_front.sv
// ---------------------------------------------------------------------------
// SVPWM front end
// Accepts requests, forms the Q2.14 products, finds the sector and picks
// the signed numerators of the two active dwell times.
// ---------------------------------------------------------------------------
module svpwm_front import svpwm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [VOLT_W-1:0]   in_alpha,
   input  logic signed [VOLT_W-1:0]   in_beta,
   input  logic [VOLT_W-1:0]          in_bus,
   output logic                       push_valid,
   input  logic                       push_ready,
   output svpwm_item_type             push_item
);

   logic                    vld_ff;
   logic signed [NUM_W-1:0] pa_ff, pb_ff, qa_ff, qb_ff, bq_ff;
   logic [VOLT_W-1:0]       bus_ff;
   logic signed [NUM_W-1:0] a32, b32;
   logic signed [NUM_W:0]   sb_val, sc_val;
   logic signed [NUM_W-1:0] nx, ny, nz;
   logic [SEC_W-1:0]        sec;
   logic                    take;

   assign a32 = NUM_W'(in_alpha);
   assign b32 = NUM_W'(in_beta);

   assign push_valid = vld_ff;
   assign take       = in_valid && in_ready;
   assign in_ready   = !vld_ff || push_ready;

   // hold the product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pa_ff  <= a32 * Q_SQRT3;
         pb_ff  <= b32 * Q_SQRT3;
         qa_ff  <= a32 * Q_THREE_HALVES;
         qb_ff  <= b32 * Q_HALF_SQRT3;
         bq_ff  <= b32 <<< Q_SHIFT;
         bus_ff <= in_bus;
      end
   end

   // sign tests and dwell numerators
   always_comb begin
      sb_val = (NUM_W+1)'(pa_ff) - (NUM_W+1)'(bq_ff);
      sc_val = (NUM_W+1)'(pa_ff) + (NUM_W+1)'(bq_ff);
      sec = {sc_val < 0, sb_val > 0, bq_ff > 0};
      nx  = pb_ff;
      ny  = qa_ff + qb_ff;
      nz  = qb_ff - qa_ff;
      push_item.sector = sec;
      push_item.bus    = bus_ff;
      unique case (sec)
         SEC_1: begin push_item.num1 = nz;  push_item.num2 = ny;  end
         SEC_2: begin push_item.num1 = ny;  push_item.num2 = -nx; end
         SEC_3: begin push_item.num1 = -nz; push_item.num2 = nx;  end
         SEC_4: begin push_item.num1 = -nx; push_item.num2 = nz;  end
         SEC_5: begin push_item.num1 = nx;  push_item.num2 = -ny; end
         SEC_6: begin push_item.num1 = -ny; push_item.num2 = -nz; end
         default: begin push_item.num1 = '0; push_item.num2 = '0; end
      endcase
   end

endmodule

>>> sv/svpwm_queue.sv
// ---------------------------------------------------------------------------
// SVPWM item queue
// Two-entry queue between the front and back ends.
// ---------------------------------------------------------------------------
module svpwm_queue import svpwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  svpwm_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_ready,
   output svpwm_item_type pop_item
);

   svpwm_item_type mem_ff [2];
   logic           wr_ff, rd_ff;
   logic [1:0]     cnt_ff;
   logic           push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

endmodule

>>> sv/svpwm_div.sv
// ---------------------------------------------------------------------------
// SVPWM divider
// Unsigned restoring divider, four quotient bits per cycle.
// ---------------------------------------------------------------------------
module svpwm_div import svpwm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DSR_W:0]   rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // four restoring steps
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int k = 0; k < RADIX_BITS; k++) begin
         rem_in = {rem_in[DSR_W-1:0], quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dsr_ff}) begin
            rem_in    = rem_in - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

>>> sv/svpwm_back.sv
// ---------------------------------------------------------------------------
// SVPWM back end
// Scales the dwell times, fits them into the period and forms the
// routed compare values in an output register.
// ---------------------------------------------------------------------------
module svpwm_back import svpwm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [TIME_W-1:0]   period,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  svpwm_item_type      pop_item,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [CMP_W-1:0]    out_cmp_a,
   output logic [CMP_W-1:0]    out_cmp_b,
   output logic [CMP_W-1:0]    out_cmp_c,
   output logic [SEC_W-1:0]    out_sector,
   output logic                out_over
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL1 = 4'd1;
   localparam logic [3:0] ST_DST1 = 4'd2;
   localparam logic [3:0] ST_DIV1 = 4'd3;
   localparam logic [3:0] ST_CHK  = 4'd4;
   localparam logic [3:0] ST_MUL2 = 4'd5;
   localparam logic [3:0] ST_DST2 = 4'd6;
   localparam logic [3:0] ST_DIV2 = 4'd7;
   localparam logic [3:0] ST_FIN  = 4'd8;

   logic [3:0]              st_ff;
   logic [SEC_W-1:0]        sec_ff;
   logic signed [NUM_W-1:0] n1_ff, n2_ff;
   logic [VOLT_W-1:0]       bus_ff;
   logic                    sg1_ff, sg2_ff, over_ff;
   logic [DIV_W-1:0]        m1_ff, m2_ff;
   logic signed [T_W-1:0]   t1_ff, t2_ff;
   logic signed [T_W:0]     sum_ff, sum_in;
   logic                    ov_ff;
   logic [CMP_W-1:0]        ca_ff, cb_ff, cc_ff;
   logic [SEC_W-1:0]        osec_ff;
   logic                    oover_ff;

   logic                    start, done1, done2, load;
   logic [DIV_W-1:0]        dvd1, dvd2, q1, q2;
   logic [DSR_W-1:0]        dsr;
   logic signed [T_W-1:0]   t1_in, t2_in;
   logic [T_W-2:0]          mag1, mag2;
   logic [NUM_W-2:0]        nm1, nm2;
   logic signed [ACC_W-1:0] pe, t1e, t2e, diff, ta, tb, tc;
   logic [CMP_W-1:0]        sa, sb, sc;

   function automatic logic [CMP_W-1:0] sat_cmp(input logic signed [ACC_W-1:0] v);
      logic [CMP_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > ACC_W'(CMP_MAX)) r = CMP_MAX;
      else r = v[CMP_W-1:0];
      return r;
   endfunction

   assign pop_ready = (st_ff == ST_IDLE);
   assign start     = (st_ff == ST_DST1) || (st_ff == ST_DST2);

   // magnitudes of numerators and dwell times
   assign nm1  = n1_ff[NUM_W-1] ? (NUM_W-1)'(-n1_ff) : n1_ff[NUM_W-2:0];
   assign nm2  = n2_ff[NUM_W-1] ? (NUM_W-1)'(-n2_ff) : n2_ff[NUM_W-2:0];
   assign mag1 = t1_ff[T_W-1] ? (T_W-1)'(-t1_ff) : t1_ff[T_W-2:0];
   assign mag2 = t2_ff[T_W-1] ? (T_W-1)'(-t2_ff) : t2_ff[T_W-2:0];

   // select divider operands per pass
   always_comb begin
      if (st_ff == ST_DST1) begin
         dvd1 = m1_ff >> Q_SHIFT;
         dvd2 = m2_ff >> Q_SHIFT;
         dsr  = (bus_ff == '0) ? DSR_W'(1) : DSR_W'(bus_ff);
      end else begin
         dvd1 = m1_ff;
         dvd2 = m2_ff;
         dsr  = sum_ff[DSR_W-1:0];
      end
   end

   svpwm_div u_div1 (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd1),
      .divisor(dsr), .done(done1), .quotient(q1)
   );

   svpwm_div u_div2 (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd2),
      .divisor(dsr), .done(done2), .quotient(q2)
   );

   assign t1_in  = sg1_ff ? -T_W'(q1) : T_W'(q1);
   assign t2_in  = sg2_ff ? -T_W'(q2) : T_W'(q2);
   assign sum_in = (T_W+1)'(t1_ff) + (T_W+1)'(t2_ff);

   // quarter and half dwell sums, truncated toward zero
   always_comb begin
      pe   = ACC_W'({1'b0, period});
      t1e  = ACC_W'(t1_ff);
      t2e  = ACC_W'(t2_ff);
      diff = pe - t1e - t2e;
      ta   = (diff + ((diff < 0) ? ACC_W'(3) : ACC_W'(0))) >>> 2;
      tb   = ta + ((t1e + ((t1e < 0) ? ACC_W'(1) : ACC_W'(0))) >>> 1);
      tc   = tb + ((t2e + ((t2e < 0) ? ACC_W'(1) : ACC_W'(0))) >>> 1);
      sa   = sat_cmp(ta);
      sb   = sat_cmp(tb);
      sc   = sat_cmp(tc);
   end

   assign load = (st_ff == ST_FIN) && (!ov_ff || out_ready);

   // sequence one item
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         unique case (st_ff)
            ST_IDLE: if (pop_valid) st_ff <= ST_MUL1;
            ST_MUL1: st_ff <= ST_DST1;
            ST_DST1: st_ff <= ST_DIV1;
            ST_DIV1: if (done1) st_ff <= ST_CHK;
            ST_CHK:  st_ff <= (sum_in > $signed((T_W+1)'({1'b0, period}))) ?
                              ST_MUL2 : ST_FIN;
            ST_MUL2: st_ff <= ST_DST2;
            ST_DST2: st_ff <= ST_DIV2;
            ST_DIV2: if (done1) st_ff <= ST_FIN;
            ST_FIN:  if (load) st_ff <= ST_IDLE;
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && pop_valid) begin
         sec_ff <= pop_item.sector;
         n1_ff  <= pop_item.num1;
         n2_ff  <= pop_item.num2;
         bus_ff <= pop_item.bus;
      end
      if (st_ff == ST_MUL1) begin
         m1_ff  <= DIV_W'(nm1) * DIV_W'(period);
         m2_ff  <= DIV_W'(nm2) * DIV_W'(period);
         sg1_ff <= n1_ff[NUM_W-1];
         sg2_ff <= n2_ff[NUM_W-1];
      end
      if (st_ff == ST_MUL2) begin
         m1_ff  <= DIV_W'(mag1) * DIV_W'(period);
         m2_ff  <= DIV_W'(mag2) * DIV_W'(period);
         sg1_ff <= t1_ff[T_W-1];
         sg2_ff <= t2_ff[T_W-1];
      end
      if ((st_ff == ST_DIV1 || st_ff == ST_DIV2) && done1) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
      end
      if (st_ff == ST_CHK) begin
         sum_ff  <= sum_in;
         over_ff <= sum_in > $signed((T_W+1)'({1'b0, period}));
      end
   end

   // route compares per sector into the output register
   always_ff @(posedge clock) begin
      if (load) begin
         osec_ff  <= sec_ff;
         oover_ff <= over_ff;
         unique case (sec_ff)
            SEC_1: begin ca_ff <= sb; cb_ff <= sa; cc_ff <= sc; end
            SEC_2: begin ca_ff <= sa; cb_ff <= sc; cc_ff <= sb; end
            SEC_3: begin ca_ff <= sa; cb_ff <= sb; cc_ff <= sc; end
            SEC_4: begin ca_ff <= sc; cb_ff <= sb; cc_ff <= sa; end
            SEC_5: begin ca_ff <= sc; cb_ff <= sa; cc_ff <= sb; end
            SEC_6: begin ca_ff <= sb; cb_ff <= sc; cc_ff <= sa; end
            default: begin ca_ff <= sa; cb_ff <= sa; cc_ff <= sa; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (load) begin
         ov_ff <= 1'b1;
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
   end

   assign out_valid  = ov_ff;
   assign out_cmp_a  = ca_ff;
   assign out_cmp_b  = cb_ff;
   assign out_cmp_c  = cc_ff;
   assign out_sector = osec_ff;
   assign out_over   = oover_ff;

   // the two dividers run in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done1 == done2) else $error("divider lanes out of step");

   // zero vector never overmodulates
   a_zero_no_over: assert property (@(posedge clock) disable iff (reset)
      ov_ff && (osec_ff == SEC_ZERO || osec_ff == SEC_ALL) |-> !oover_ff)
      else $error("overmodulation flagged for zero vector");

   // zero vector gives equal compares
   a_zero_equal: assert property (@(posedge clock) disable iff (reset)
      ov_ff && osec_ff == SEC_ZERO |-> (ca_ff == cb_ff) && (cb_ff == cc_ff))
      else $error("zero vector compares differ");

   // no divider result outside a division state
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      done1 |-> (st_ff == ST_DIV1 || st_ff == ST_DIV2))
      else $error("divider finished outside a division");

endmodule

>>> sv/svpwm_seven_segment_timing_top.sv
// ---------------------------------------------------------------------------
// Seven-segment SVPWM timing
// Turns an alpha/beta voltage request and the bus voltage into three
// phase compare values, the sector code and an overmodulation flag.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one request per handshake: alpha, beta, bus voltage.
//   rsp_* returns one result per request, in order.
//   csr_* writes the carrier period (reset value 5000); write it only
//   while no request is in flight.
// Flow: the back end takes one item at a time and holds it until its result
// is loaded; each item takes one pass of the two radix-16 dividers, and a
// second pass when the dwell times must be scaled to fit the period. The
// front end takes a request every cycle until the two-entry queue fills.
// Reset clears the queue, the sequencer and the result valid flag and loads
// the default period. When the receiver stalls the result register holds,
// the back end waits, and the queue and front end fill before req_tready
// drops.
// ---------------------------------------------------------------------------
module svpwm_seven_segment_timing_top import svpwm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // volt_alpha, volt_beta, bus_voltage
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // compare_phase_a, _b, _c, zero pad
   output logic [3:0]   rsp_tuser,   // sector_code, over_modulated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   logic [TIME_W-1:0] period_ff;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   svpwm_item_type    push_item, pop_item;
   logic [CMP_W-1:0]  cmp_a, cmp_b, cmp_c;
   logic [SEC_W-1:0]  sector;
   logic              over;

   assign csr_ready = 1'b1;

   // hold the carrier period
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_valid) begin
         period_ff <= csr_data;
      end
   end

   svpwm_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_alpha(req_tdata[15:0]), .in_beta(req_tdata[31:16]),
      .in_bus(req_tdata[47:32]),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item)
   );

   svpwm_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_item(push_item),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item)
   );

   svpwm_back u_back (
      .clock(clock), .reset(reset), .period(period_ff),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_item(pop_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_cmp_a(cmp_a), .out_cmp_b(cmp_b), .out_cmp_c(cmp_c),
      .out_sector(sector), .out_over(over)
   );

   assign rsp_tdata = {3'b000, cmp_c, cmp_b, cmp_a};
   assign rsp_tuser = {over, sector};

endmodule

>>> tb/svpwm_seven_segment_timing_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Seven-segment SVPWM timing testbench
// Drives alpha/beta/bus requests through the stream ports with random gaps
// and stalls, predicts the compares, sector and overmodulation flag, and
// checks each result in order. The carrier period is rewritten while idle.
// ---------------------------------------------------------------------------
module svpwm_seven_segment_timing_top_tb;
   import svpwm_pkg::*;

   typedef struct packed {
      logic [CMP_W-1:0] cmp_a;
      logic [CMP_W-1:0] cmp_b;
      logic [CMP_W-1:0] cmp_c;
      logic [SEC_W-1:0] sector;
      logic             over;
   } timing_type;

   typedef struct {
      logic [15:0] alpha;
      logic [15:0] beta;
      logic [15:0] bus;
      bit          known;
      timing_type  res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   timing_type  timing_queue[$];
   logic [15:0] period = PERIOD_RESET;
   int          fail_count = 0;
   bit          stim_done = 1'b0;

   always #2 clock = ~clock;

   svpwm_seven_segment_timing_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // trunc(n*m/d) toward zero, d > 0
   function automatic longint scale_trunc(longint n, longint m, longint d);
      longint mag;
      mag = (n < 0) ? -n : n;
      mag = mag * m / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic logic [CMP_W-1:0] clamp_cmp(longint v);
      if (v < 0) return '0;
      if (v > 32767) return CMP_MAX;
      return v[CMP_W-1:0];
   endfunction

   function automatic timing_type predict_timing(logic [15:0] ra, logic [15:0] rb,
                                                 logic [15:0] rbus, logic [15:0] per);
      longint a, b, u, p, bq, x, y, z, t1, t2, ta, tb, tc, sum, d;
      logic [2:0] sec;
      timing_type r;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      u = (rbus == 0) ? 1 : longint'(rbus);
      p = longint'(per);
      bq = b * 16384;
      sec = {(28377 * a + bq < 0), (28377 * a - bq > 0), (b > 0)};
      d = u * 16384;
      x = scale_trunc(28377 * b, p, d);
      y = scale_trunc(24576 * a + 14189 * b, p, d);
      z = scale_trunc(-24576 * a + 14189 * b, p, d);
      t1 = 0;
      t2 = 0;
      case (sec)
         SEC_1: begin t1 = z;  t2 = y;  end
         SEC_2: begin t1 = y;  t2 = -x; end
         SEC_3: begin t1 = -z; t2 = x;  end
         SEC_4: begin t1 = -x; t2 = z;  end
         SEC_5: begin t1 = x;  t2 = -y; end
         SEC_6: begin t1 = -y; t2 = -z; end
         default: ;
      endcase
      r.over = 1'b0;
      sum = t1 + t2;
      if (sum > p) begin
         r.over = 1'b1;
         t1 = scale_trunc(t1, p, sum);
         t2 = scale_trunc(t2, p, sum);
      end
      ta = (p - t1 - t2) / 4;
      tb = ta + t1 / 2;
      tc = tb + t2 / 2;
      case (sec)
         SEC_1: begin r.cmp_a = clamp_cmp(tb); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(tc); end
         SEC_2: begin r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(tc); r.cmp_c = clamp_cmp(tb); end
         SEC_3: begin r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(tb); r.cmp_c = clamp_cmp(tc); end
         SEC_4: begin r.cmp_a = clamp_cmp(tc); r.cmp_b = clamp_cmp(tb); r.cmp_c = clamp_cmp(ta); end
         SEC_5: begin r.cmp_a = clamp_cmp(tc); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(tb); end
         SEC_6: begin r.cmp_a = clamp_cmp(tb); r.cmp_b = clamp_cmp(tc); r.cmp_c = clamp_cmp(ta); end
         default: begin
            r.cmp_a = clamp_cmp(ta); r.cmp_b = clamp_cmp(ta); r.cmp_c = clamp_cmp(ta);
         end
      endcase
      r.sector = sec;
      return r;
   endfunction

   // Send one request and queue its expected timing; valid stays high after
   // the handshake so that a back-to-back request needs no second drive
   task automatic send_request(logic [15:0] ra, logic [15:0] rb, logic [15:0] rbus,
                               bit known, timing_type typed);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {rbus, rb, ra};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      timing_queue.push_back(known ? typed : predict_timing(ra, rb, rbus, period));
      @(negedge clock);
   endtask

   // Wait for all results, let the back end settle, then write the period
   task automatic write_period(logic [15:0] value);
      req_tvalid <= 1'b0;
      while (timing_queue.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      period = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: random stalls, compare field by field
   initial begin : result_check
      timing_type got, want;
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, 12);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tdata[14:0], rsp_tdata[29:15], rsp_tdata[44:30],
                rsp_tuser[2:0], rsp_tuser[3]};
         if (timing_queue.size() == 0) begin
            $error("result with no request waiting");
            fail_count++;
         end else begin
            want = timing_queue.pop_front();
            if (got.cmp_a !== want.cmp_a) begin
               $error("compare_phase_a expected %0d got %0d", want.cmp_a, got.cmp_a);
               fail_count++;
            end
            if (got.cmp_b !== want.cmp_b) begin
               $error("compare_phase_b expected %0d got %0d", want.cmp_b, got.cmp_b);
               fail_count++;
            end
            if (got.cmp_c !== want.cmp_c) begin
               $error("compare_phase_c expected %0d got %0d", want.cmp_c, got.cmp_c);
               fail_count++;
            end
            if (got.sector !== want.sector) begin
               $error("sector_code expected %0d got %0d", want.sector, got.sector);
               fail_count++;
            end
            if (got.over !== want.over) begin
               $error("over_modulated expected %0d got %0d", want.over, got.over);
               fail_count++;
            end
         end
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin : stimulus
      stim_row_type rows[$];
      stim_row_type row;
      logic [15:0] periods[6];
      logic [15:0] ra, rb, rbus;
      int mag, k;
      periods = '{16'd1, 16'd65535, 16'd3000, 16'd100, 16'd0, 16'd20000};

      // Directed rows; typed results only for zero vectors
      row.known = 1'b1;
      row.alpha = 0; row.beta = 0; row.bus = 16'd100;
      row.res = '{15'd1250, 15'd1250, 15'd1250, SEC_ZERO, 1'b0};
      rows.push_back(row);
      row.bus = 16'd0;       // zero bus voltage, still zero vector
      rows.push_back(row);
      row.bus = 16'hFFFF;
      rows.push_back(row);
      row.known = 1'b0;
      row.alpha = 16'sd1000;  row.beta = 16'sd500;  row.bus = 16'd4000; rows.push_back(row);
      row.alpha = 16'sd100;   row.beta = 16'sd1000; row.bus = 16'd4000; rows.push_back(row);
      row.alpha = -16'sd100;  row.beta = 16'sd1000; row.bus = 16'd4000; rows.push_back(row);
      row.alpha = -16'sd1000; row.beta = 16'sd200;  row.bus = 16'd4000; rows.push_back(row);
      row.alpha = -16'sd1000; row.beta = -16'sd200; row.bus = 16'd4000; rows.push_back(row);
      row.alpha = 16'sd100;   row.beta = -16'sd1000;row.bus = 16'd4000; rows.push_back(row);
      row.alpha = 16'sd1000;  row.beta = -16'sd500; row.bus = 16'd4000; rows.push_back(row);
      row.alpha = 16'sd1000;  row.beta = 0;         row.bus = 16'd4000; rows.push_back(row);
      row.alpha = 16'h7FFF;   row.beta = 16'h7FFF;  row.bus = 16'd1;    rows.push_back(row);
      row.alpha = 16'h8000;   row.beta = 16'h8000;  row.bus = 16'd1;    rows.push_back(row);
      row.alpha = 16'h7FFF;   row.beta = 16'h8000;  row.bus = 16'hFFFF; rows.push_back(row);
      row.alpha = 16'h8000;   row.beta = 16'h7FFF;  row.bus = 16'd0;    rows.push_back(row);
      row.alpha = 16'sd20000; row.beta = 16'sd9000; row.bus = 16'd10000;rows.push_back(row);
      row.alpha = 16'sd5;     row.beta = -16'sd3;   row.bus = 16'd1;    rows.push_back(row);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].alpha, rows[i].beta, rows[i].bus, rows[i].known, rows[i].res);

      // Random phases over several periods, extremes among them
      for (int ph = 0; ph < 6; ph++) begin
         write_period(periods[ph]);
         for (int n = 0; n < 175; n++) begin
            k = $urandom_range(0, 9);
            mag = (k < 3) ? 300 : ((k < 6) ? 4000 : 32767);
            ra = 16'($signed($urandom_range(0, 2 * mag)) - mag);
            rb = 16'($signed($urandom_range(0, 2 * mag)) - mag);
            if (k == 9) begin
               ra = $urandom();
               rb = $urandom();
            end
            if (k == 8) rb = 0;
            rbus = (k < 5) ? 16'($urandom_range(1, 8000)) : 16'($urandom());
            send_request(ra, rb, rbus, 1'b0, '0);
            // let the pipe drain once per phase
            if (n == 90) begin
               req_tvalid <= 1'b0;
               @(negedge clock);
               while (timing_queue.size() != 0) @(negedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run
   initial begin : finish_run
      @(posedge clock);
      while (!stim_done || timing_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && timing_queue.size() == 0)
         $display("svpwm_seven_segment_timing_top_tb passed");
      else
         $display("svpwm_seven_segment_timing_top_tb failed");
      $finish;
   end

   // Timeout
   initial begin : watchdog
      #2000000;
      $display("svpwm_seven_segment_timing_top_tb failed");
      $finish;
   end

endmodule

>>> filelist.f
sv/svpwm_pkg.sv
sv/svpwm_front.sv
sv/svpwm_queue.sv
sv/svpwm_div.sv
sv/svpwm_back.sv
sv/svpwm_seven_segment_timing_top.sv
tb/svpwm_seven_segment_timing_top_tb.sv
